>>> rtl/ced_pkg.sv
// Shared types, character codes and lookup functions for the escape decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package ced_pkg;

  // Escape run lengths
  localparam logic [1:0] MAX_OCT_DIGITS = 2'd3;
  localparam logic [1:0] MAX_HEX_DIGITS = 2'd2;

  // Depth of the front-to-back request queue
  localparam int QUEUE_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_EMPTY_HEX = 2'd2,
    ST_TRAILING  = 2'd3
  } status_t;

  // One request: up to two results caused by one character.
  // The optional first result is always a flushed numeric escape.
  typedef struct packed {
    logic       has_first;
    logic [7:0] first_byte;
    logic [7:0] main_byte;
    logic       main_valid;
    status_t    main_status;
    logic       fin;
  } op_t;

  // {hit, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [CH_0:CH_9]:   r = {1'b1, 4'(c - CH_0)};
      [CH_UA:CH_UF]: r = {1'b1, 4'(c - CH_UA + 8'd10)};
      [CH_LA:CH_LF]: r = {1'b1, 4'(c - CH_LA + 8'd10)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  // Single-letter escapes: {hit, byte}
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h27:   r = {1'b1, 8'h27}; // '
      8'h22:   r = {1'b1, 8'h22}; // "
      8'h3F:   r = {1'b1, 8'h3F}; // ?
      8'h5C:   r = {1'b1, 8'h5C}; // backslash
      8'h61:   r = {1'b1, 8'h07}; // a
      8'h62:   r = {1'b1, 8'h08}; // b
      8'h66:   r = {1'b1, 8'h0C}; // f
      8'h6E:   r = {1'b1, 8'h0A}; // n
      8'h72:   r = {1'b1, 8'h0D}; // r
      8'h74:   r = {1'b1, 8'h09}; // t
      8'h76:   r = {1'b1, 8'h0B}; // v
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ced_front.sv
// Front end: accepts characters, runs the escape parser, builds requests.
// Depends on ced_pkg.
`default_nettype none

module ced_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         q_ready,
  output logic              push,
  output ced_pkg::op_t      op
);

  typedef enum logic [4:0] {
    M_NORMAL    = 5'b00001,
    M_BSLASH    = 5'b00010,
    M_OCTAL     = 5'b00100,
    M_HEX_START = 5'b01000,
    M_HEX       = 5'b10000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       disc_r, disc_nxt;

  logic [7:0] c;
  logic       fin;
  logic       accept;
  logic       emit;
  logic       err;
  logic       is_oct;
  logic [4:0] hx;
  logic [8:0] esc;
  logic [1:0] cnt_inc;

  // plain character handling
  logic       p_emit;
  logic       p_err;
  mode_t      p_mode;
  logic [7:0] p_byte;
  logic       p_valid;
  ced_pkg::status_t p_status;

  assign c         = in_tdata;
  assign fin       = in_tlast;
  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign push      = accept && emit;
  assign is_oct    = (c >= ced_pkg::CH_0) && (c <= ced_pkg::CH_7);
  assign hx        = ced_pkg::hex_nibble(c);
  assign esc       = ced_pkg::esc_byte(c);
  assign cnt_inc   = cnt_r + 2'd1;

  always_comb begin
    p_emit   = 1'b0;
    p_err    = 1'b0;
    p_mode   = M_NORMAL;
    p_byte   = 8'd0;
    p_valid  = 1'b0;
    p_status = ced_pkg::ST_OK;
    if (c == ced_pkg::CH_BSLASH) begin
      if (fin) begin
        p_emit   = 1'b1;
        p_err    = 1'b1;
        p_status = ced_pkg::ST_TRAILING;
      end else begin
        p_mode = M_BSLASH;
      end
    end else begin
      p_emit  = 1'b1;
      p_byte  = c;
      p_valid = 1'b1;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    disc_nxt = disc_r;
    emit     = 1'b0;
    err      = 1'b0;
    op       = '0;
    op.fin   = fin;
    if (disc_r) begin
      emit = fin;
    end else begin
      case (mode_r)
        M_BSLASH: begin
          mode_nxt = M_NORMAL;
          if (is_oct) begin
            acc_nxt = {5'd0, c[2:0]};
            cnt_nxt = 2'd1;
            if (fin || (2'd1 >= ced_pkg::MAX_OCT_DIGITS)) begin
              emit          = 1'b1;
              op.main_byte  = {5'd0, c[2:0]};
              op.main_valid = 1'b1;
            end else begin
              mode_nxt = M_OCTAL;
            end
          end else if (c == ced_pkg::CH_X) begin
            acc_nxt = 8'd0;
            cnt_nxt = 2'd0;
            if (fin) begin
              emit           = 1'b1;
              err            = 1'b1;
              op.main_status = ced_pkg::ST_EMPTY_HEX;
            end else begin
              mode_nxt = M_HEX_START;
            end
          end else if (esc[8]) begin
            emit          = 1'b1;
            op.main_byte  = esc[7:0];
            op.main_valid = 1'b1;
          end else begin
            emit           = 1'b1;
            err            = 1'b1;
            op.main_status = ced_pkg::ST_UNKNOWN;
          end
        end
        M_OCTAL: begin
          if (is_oct) begin
            acc_nxt = {acc_r[4:0], c[2:0]};
            cnt_nxt = cnt_inc;
            if (fin || (cnt_inc >= ced_pkg::MAX_OCT_DIGITS)) begin
              mode_nxt      = M_NORMAL;
              emit          = 1'b1;
              op.main_byte  = {acc_r[4:0], c[2:0]};
              op.main_valid = 1'b1;
            end
          end else begin
            // flush pending byte, then decode the terminator itself
            emit     = 1'b1;
            mode_nxt = p_mode;
            err      = p_err;
            if (p_emit) begin
              op.has_first   = 1'b1;
              op.first_byte  = acc_r;
              op.main_byte   = p_byte;
              op.main_valid  = p_valid;
              op.main_status = p_status;
            end else begin
              op.main_byte  = acc_r;
              op.main_valid = 1'b1;
            end
          end
        end
        M_HEX_START: begin
          if (!hx[4]) begin
            mode_nxt       = M_NORMAL;
            emit           = 1'b1;
            err            = 1'b1;
            op.main_status = ced_pkg::ST_EMPTY_HEX;
          end else begin
            acc_nxt  = {4'd0, hx[3:0]};
            cnt_nxt  = 2'd1;
            mode_nxt = M_HEX;
            if (fin || (2'd1 >= ced_pkg::MAX_HEX_DIGITS)) begin
              mode_nxt      = M_NORMAL;
              emit          = 1'b1;
              op.main_byte  = {4'd0, hx[3:0]};
              op.main_valid = 1'b1;
            end
          end
        end
        M_HEX: begin
          if (hx[4]) begin
            acc_nxt = {acc_r[3:0], hx[3:0]};
            cnt_nxt = cnt_inc;
            if (fin || (cnt_inc >= ced_pkg::MAX_HEX_DIGITS)) begin
              mode_nxt      = M_NORMAL;
              emit          = 1'b1;
              op.main_byte  = {acc_r[3:0], hx[3:0]};
              op.main_valid = 1'b1;
            end
          end else begin
            emit     = 1'b1;
            mode_nxt = p_mode;
            err      = p_err;
            if (p_emit) begin
              op.has_first   = 1'b1;
              op.first_byte  = acc_r;
              op.main_byte   = p_byte;
              op.main_valid  = p_valid;
              op.main_status = p_status;
            end else begin
              op.main_byte  = acc_r;
              op.main_valid = 1'b1;
            end
          end
        end
        default: begin
          emit           = p_emit;
          err            = p_err;
          mode_nxt       = p_mode;
          op.main_byte   = p_byte;
          op.main_valid  = p_valid;
          op.main_status = p_status;
        end
      endcase
      if (err) begin
        mode_nxt = M_NORMAL;
        disc_nxt = 1'b1;
      end
    end
    // end of string: back to reset state
    if (fin) begin
      mode_nxt = M_NORMAL;
      cnt_nxt  = 2'd0;
      acc_nxt  = 8'd0;
      disc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      cnt_r  <= 2'd0;
      acc_r  <= 8'd0;
      disc_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ced_queue.sv
// Small FIFO of parser requests between front and back end.
// Depends on ced_pkg for the request type.
`default_nettype none

module ced_queue #(
  parameter int DEPTH = ced_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ced_pkg::op_t  push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               head_valid,
  output ced_pkg::op_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ced_pkg::op_t  mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_IDX) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_IDX) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ced_back.sv
// Back end: expands each request into one or two results in an output register.
// Depends on ced_pkg for the request and status types.
`default_nettype none

module ced_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire ced_pkg::op_t  head,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);

  logic             vld_r, vld_nxt;
  logic             phase_r, phase_nxt;
  logic             load;
  logic             take_first;
  logic [7:0]       byte_r;
  logic             bvalid_r;
  ced_pkg::status_t status_r;
  logic             run_last_r;
  logic             done_r;

  assign load       = head_valid && (!vld_r || out_tready);
  assign take_first = head.has_first && !phase_r;
  assign pop        = load && !take_first;

  always_comb begin
    vld_nxt   = vld_r;
    phase_nxt = phase_r;
    if (load) begin
      vld_nxt   = 1'b1;
      phase_nxt = take_first;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_first) begin
        byte_r     <= head.first_byte;
        bvalid_r   <= 1'b1;
        status_r   <= ced_pkg::ST_OK;
        run_last_r <= 1'b0;
        done_r     <= 1'b0;
      end else begin
        byte_r     <= head.main_byte;
        bvalid_r   <= head.main_valid;
        status_r   <= head.main_status;
        run_last_r <= 1'b1;
        done_r     <= head.fin;
      end
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {7'd0, run_last_r, byte_r};
  assign out_tuser  = {status_r, bvalid_r};
  assign out_tlast  = done_r;

endmodule

`default_nettype wire

>>> rtl/c_escape_sequence_decoder.sv
// Top level of the C string escape decoder: parser front end, request queue,
// result back end. Depends on ced_pkg, ced_front, ced_queue and ced_back.
//
//  channel | dir | tdata                          | tuser                        | tlast
//  --------+-----+--------------------------------+------------------------------+------------
//  in_     | in  | [7:0] char_in                  | -                            | is_final
//  out_    | out | [7:0] out_byte, [8] run_last   | [0] byte_valid, [2:1] status | string_done
//
// One character is accepted per cycle while the request queue has room.
// A character that flushes a pending octal/hex byte and decodes itself yields
// two results; the back end expands it while the front keeps parsing.
// Each request is written into the queue, then loaded into the output register.
// rst_n is synchronous: it clears the parser state, the queue and the output
// valid flag. A stalled output fills the queue; in_tready drops when it is full.
`default_nettype none

module c_escape_sequence_decoder #(
  parameter int QUEUE_DEPTH = ced_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tlast,   // is_final
  // results out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] run_last, rest zero
  output logic [2:0]       out_tuser,  // [0] byte_valid, [2:1] status
  output logic             out_tlast   // string_done
);

  ced_pkg::op_t op;
  ced_pkg::op_t head;
  logic         push;
  logic         q_ready;
  logic         pop;
  logic         head_valid;

  // Front: parse state advances on every accepted character; only
  // characters that produce results push a request.
  ced_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .push      (push),
    .op        (op)
  );

  // Decouples the parser from output back-pressure.
  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (op),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: one result per cycle from the queue head into the output register, unless out_tready stalls it.
  ced_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for c_escape_sequence_decoder: streams escaped strings,
// predicts the decoded bytes and status in a local decoder model, checks each result.
// Depends on ced_pkg and the RTL top level only.
`default_nettype none

module testbench;

  // Parser modes of the local decoder
  typedef enum logic [2:0] {
    M_NORMAL,
    M_BSLASH,
    M_OCTAL,
    M_HEX_START,
    M_HEX
  } parse_mode_t;

  // One decoded result as seen on the out_ channel
  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             done;
    ced_pkg::status_t status;
    logic             run_last;
  } dec_result_t;

  localparam string SIMPLE_ESC = "'\"?\\abfnrtv";
  localparam string HEX_CHARS  = "0123456789abcdefABCDEF";
  localparam int    DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Local decoder state
  parse_mode_t mode_q;
  logic [1:0]  digits_q;
  logic [7:0]  acc_q;
  logic        discard_q;

  dec_result_t step_res[$];          // results of the character being decoded
  dec_result_t expected_results[$];  // decoded results still to come out
  logic [7:0]  text_q[$];            // string being assembled for sending

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int fail_count = 0;

  c_escape_sequence_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- decoder model

  function automatic void clear_decoder();
    mode_q    = M_NORMAL;
    digits_q  = 2'd0;
    acc_q     = 8'h00;
    discard_q = 1'b0;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic v,
                                     input ced_pkg::status_t st);
    dec_result_t r;
    r.data     = v ? b : 8'h00;
    r.valid    = v;
    r.done     = 1'b0;
    r.status   = st;
    r.run_last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  // Append one character to the string being assembled
  function automatic void add_text(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= ced_pkg::CH_0) && (c <= ced_pkg::CH_7);
  endfunction

  // 1 and the nibble value when c is a hex digit of either case
  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'd0;
    if (c >= ced_pkg::CH_0 && c <= ced_pkg::CH_9) begin
      nib = c[3:0];
      return 1'b1;
    end
    if ((c >= ced_pkg::CH_UA && c <= ced_pkg::CH_UF) ||
        (c >= ced_pkg::CH_LA && c <= ced_pkg::CH_LF)) begin
      nib = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void take_plain(input logic [7:0] c, input logic fin);
    if (c == ced_pkg::CH_BSLASH) begin
      if (fin) add_result(8'h00, 1'b0, ced_pkg::ST_TRAILING);
      else mode_q = M_BSLASH;
    end else begin
      mode_q = M_NORMAL;
      add_result(c, 1'b1, ced_pkg::ST_OK);
    end
  endfunction

  function automatic void take_escape(input logic [7:0] c, input logic fin);
    logic [7:0] b;
    logic       hit;
    mode_q = M_NORMAL;
    if (is_octal(c)) begin
      acc_q    = {5'd0, c[2:0]};
      digits_q = 2'd1;
      if (fin || digits_q >= ced_pkg::MAX_OCT_DIGITS) add_result(acc_q, 1'b1, ced_pkg::ST_OK);
      else mode_q = M_OCTAL;
    end else if (c == ced_pkg::CH_X) begin
      acc_q    = 8'h00;
      digits_q = 2'd0;
      if (fin) add_result(8'h00, 1'b0, ced_pkg::ST_EMPTY_HEX);
      else mode_q = M_HEX_START;
    end else begin
      hit = 1'b1;
      case (c)
        "'":     b = 8'h27;
        "\"":    b = 8'h22;
        "?":     b = 8'h3F;
        "\\":    b = 8'h5C;
        "a":     b = 8'h07;
        "b":     b = 8'h08;
        "f":     b = 8'h0C;
        "n":     b = 8'h0A;
        "r":     b = 8'h0D;
        "t":     b = 8'h09;
        "v":     b = 8'h0B;
        default: begin
          b   = 8'h00;
          hit = 1'b0;
        end
      endcase
      if (hit) add_result(b, 1'b1, ced_pkg::ST_OK);
      else add_result(8'h00, 1'b0, ced_pkg::ST_UNKNOWN);
    end
  endfunction

  // Decode one accepted character and queue the results it produces
  function automatic void decode_char(input logic [7:0] c, input logic fin);
    logic [3:0] nib;
    logic       is_hex;
    logic       had_err;
    step_res.delete();
    is_hex = hex_digit(c, nib);
    if (discard_q) begin
      if (fin) add_result(8'h00, 1'b0, ced_pkg::ST_OK);
    end else begin
      case (mode_q)
        M_BSLASH: take_escape(c, fin);
        M_OCTAL: begin
          if (is_octal(c)) begin
            acc_q    = {acc_q[4:0], c[2:0]};
            digits_q = digits_q + 2'd1;
            if (fin || digits_q >= ced_pkg::MAX_OCT_DIGITS) begin
              mode_q = M_NORMAL;
              add_result(acc_q, 1'b1, ced_pkg::ST_OK);
            end
          end else begin
            add_result(acc_q, 1'b1, ced_pkg::ST_OK);
            take_plain(c, fin);
          end
        end
        M_HEX_START: begin
          if (!is_hex) begin
            mode_q = M_NORMAL;
            add_result(8'h00, 1'b0, ced_pkg::ST_EMPTY_HEX);
          end else begin
            acc_q    = {4'd0, nib};
            digits_q = 2'd1;
            mode_q   = M_HEX;
            if (fin || digits_q >= ced_pkg::MAX_HEX_DIGITS) begin
              mode_q = M_NORMAL;
              add_result(acc_q, 1'b1, ced_pkg::ST_OK);
            end
          end
        end
        M_HEX: begin
          if (is_hex) begin
            acc_q    = {acc_q[3:0], nib};
            digits_q = digits_q + 2'd1;
            if (fin || digits_q >= ced_pkg::MAX_HEX_DIGITS) begin
              mode_q = M_NORMAL;
              add_result(acc_q, 1'b1, ced_pkg::ST_OK);
            end
          end else begin
            add_result(acc_q, 1'b1, ced_pkg::ST_OK);
            take_plain(c, fin);
          end
        end
        default: take_plain(c, fin);
      endcase
      had_err = 1'b0;
      foreach (step_res[i]) if (!step_res[i].valid) had_err = 1'b1;
      // any error drops the rest of the string
      if (had_err) begin
        mode_q    = M_NORMAL;
        discard_q = 1'b1;
      end
    end
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].run_last = 1'b1;
      if (fin) step_res[step_res.size() - 1].done = 1'b1;
    end
    foreach (step_res[i]) expected_results.insert(expected_results.size(), step_res[i]);
    if (fin) clear_decoder();
  endfunction

  // ---------------------------------------------------------------- result check

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dec_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata 0x%0h tuser 0x%0h tlast %0b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("out_byte", exp_r.data, out_tdata[7:0]);
        check_field("byte_valid", exp_r.valid, out_tuser[0]);
        check_field("string_done", exp_r.done, out_tlast);
        check_field("status", exp_r.status, out_tuser[2:1]);
        check_field("run_last", exp_r.run_last, out_tdata[8]);
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------- stimulus

  // One request on in_; tvalid stays high after acceptance until the next call
  task automatic send_char(input logic [7:0] c, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    decode_char(c, fin);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_literal(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Append one escape-text segment; most are well formed
  function automatic void append_segment();
    int         kind;
    int         n;
    logic [7:0] c;
    logic [3:0] nib;
    kind = $urandom_range(99);
    if (kind < 30) begin
      c = 8'($urandom_range(255));
      if (c == ced_pkg::CH_BSLASH) add_text(ced_pkg::CH_BSLASH);
      add_text(c);
    end else if (kind < 45) begin
      add_text(ced_pkg::CH_BSLASH);
      add_text(pick_char(SIMPLE_ESC));
    end else if (kind < 65) begin
      add_text(ced_pkg::CH_BSLASH);
      n = $urandom_range(3, 1);
      repeat (n) add_text(ced_pkg::CH_0 + 8'($urandom_range(7)));
    end else if (kind < 82) begin
      add_text(ced_pkg::CH_BSLASH);
      add_text(ced_pkg::CH_X);
      n = $urandom_range(2, 1);
      repeat (n) add_text(pick_char(HEX_CHARS));
    end else begin
      add_text(ced_pkg::CH_BSLASH);
      case ($urandom_range(3))
        0: add_text(8'($urandom_range(255)));  // mostly unknown escapes
        1: begin
          c = 8'($urandom_range(255));
          if (hex_digit(c, nib)) c = "Z";
          add_text(ced_pkg::CH_X);
          add_text(c);
        end
        2: add_text(ced_pkg::CH_X);  // bare \x, empty at string end
        default: ;                   // lone backslash
      endcase
    end
  endfunction

  task automatic test_plain_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_literal("\\a\\v");
  endtask

  task automatic test_octal();
    send_literal("\\1017");     // three digits, then plain
    send_literal("\\777\\1");   // wraps to 8 bits; one digit flushed at string end
    send_literal("\\12\\");     // flush plus trailing backslash from one character
  endtask

  task automatic test_hex();
    send_literal("\\xfF\\xA");  // both cases, single digit at string end
    send_literal("\\x4g");      // run ended by a plain character
  endtask

  task automatic test_errors();
    send_literal("\\xzQ");      // empty hex escape, then discarded tail
    send_literal("\\q");        // unknown escape
    send_literal("\\");         // trailing backslash
    send_literal("\\x");        // bare \x at string end
  endtask

  task automatic test_random_strings(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      repeat ($urandom_range(6, 1)) append_segment();
      send_text();
    end
  endtask

  task automatic test_noise(input int n_items);
    int target;
    int r;
    target = items_sent + n_items;
    while (items_sent < target) begin
      repeat ($urandom_range(8, 1)) begin
        r = $urandom_range(99);
        if (r < 25) add_text(ced_pkg::CH_BSLASH);
        else if (r < 35) add_text(ced_pkg::CH_X);
        else if (r < 55) add_text(ced_pkg::CH_0 + 8'($urandom_range(9)));
        else add_text(8'($urandom_range(255)));
      end
      send_text();
    end
  endtask

  initial begin
    clear_decoder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_extremes();
    test_octal();
    test_hex();
    test_errors();

    // idle / stall phases
    test_random_strings(200);
    idle_pct  = 58;
    test_random_strings(200);
    idle_pct  = 0;
    stall_pct = 58;
    test_random_strings(200);
    idle_pct  = 37;
    stall_pct = 37;
    test_random_strings(200);
    test_noise(100);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> c_escape_sequence_decoder.f
rtl/ced_pkg.sv
rtl/ced_front.sv
rtl/ced_queue.sv
rtl/ced_back.sv
rtl/c_escape_sequence_decoder.sv
dv/testbench.sv
